@@ rtl/core/image_rotate_flip_address_unit_defines.svh @@
// ----------------------------------------------------------------------------
// image rotate / flip address unit assertion macros
// shared concurrent assertion forms, clocked on clk with async reset rst_n
// ----------------------------------------------------------------------------
`ifndef IMAGE_ROTATE_FLIP_ADDRESS_UNIT_DEFINES_SVH
`define IMAGE_ROTATE_FLIP_ADDRESS_UNIT_DEFINES_SVH

// same-cycle implication
`define IRFA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IRFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/irfa_pkg.sv @@
// ----------------------------------------------------------------------------
// irfa_pkg
// widths, register indexes and the result record of the rotate/flip address unit
// ----------------------------------------------------------------------------
package irfa_pkg;

    localparam int OFS_W  = 26;   // destination byte offset
    localparam int PIX_W  = 24;   // pixel value
    localparam int SIZE_W = 13;   // width / height registers
    localparam int ROT_W  = 2;    // signed rotate direction
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;

    // register index, taken from paddr[4:2]
    localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] REG_TRUE_COLOR = 3'd2;
    localparam logic [IDX_W-1:0] REG_ROTATE_DIR = 3'd3;
    localparam logic [IDX_W-1:0] REG_FLIP_X     = 3'd4;
    localparam logic [IDX_W-1:0] REG_FLIP_Y     = 3'd5;

    localparam logic [ROT_W-1:0] ROT_CW = 2'b01;

    typedef struct packed {
        logic [OFS_W-1:0] dest_offset;
        logic [PIX_W-1:0] pixel;
        logic             last;
    } result_t;

endpackage

@@ rtl/core/image_rotate_flip_address_unit.sv @@
// ----------------------------------------------------------------------------
// image_rotate_flip_address_unit
// destination byte offset of each source pixel after quarter turn and mirroring
// ----------------------------------------------------------------------------
//  channel   signals                                         direction
//  in        in_valid, in_stall, pixel_value                 request in
//  out       out_valid, out_stall, dest_offset,
//            pixel_out, last_pixel                           request out
//  cfg       psel, penable, pwrite, paddr, pwdata, prdata,
//            pready                                          register access
//
//  one pixel per clock while in_stall is low; each result is registered in the
//  result register or skid entry; the offset walk (add of the x or y step to
//  the running offset) is the loop that sets this rate; the image start offset
//  needs one multiply of row index by stride in the same cycle
//  reset clears the walk counters, the output stage and the registers
//  a two-entry output stage (result register plus skid) keeps input flowing
//  while out_stall is high; in_stall rises only when both entries are full
// ----------------------------------------------------------------------------
`include "image_rotate_flip_address_unit_defines.svh"

module image_rotate_flip_address_unit #(
    parameter int MAX_DIM = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // pixel input
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [irfa_pkg::PIX_W-1:0]      pixel_value,
    // address output
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [irfa_pkg::OFS_W-1:0]      dest_offset,
    output logic [irfa_pkg::PIX_W-1:0]      pixel_out,
    output logic                            last_pixel,
    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [irfa_pkg::ADDR_W-1:0]     paddr,
    input  logic [irfa_pkg::DATA_W-1:0]     pwdata,
    output logic [irfa_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int STR_W = DIM_W + 2;
    localparam int PRD_W = DIM_W + STR_W;
    localparam int XB_W  = DIM_W + 2;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    logic [irfa_pkg::SIZE_W-1:0]        src_width_reg;
    logic [irfa_pkg::SIZE_W-1:0]        src_height_reg;
    logic                               true_color_reg;
    logic signed [irfa_pkg::ROT_W-1:0]  rotate_dir_reg;
    logic                               flip_x_reg;
    logic                               flip_y_reg;

    logic                               cfg_write;
    logic [irfa_pkg::IDX_W-1:0]         cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= irfa_pkg::SIZE_W'(1);
            src_height_reg <= irfa_pkg::SIZE_W'(1);
            true_color_reg <= 1'b0;
            rotate_dir_reg <= '0;
            flip_x_reg     <= 1'b0;
            flip_y_reg     <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                irfa_pkg::REG_SRC_WIDTH:  src_width_reg  <= pwdata[irfa_pkg::SIZE_W-1:0];
                irfa_pkg::REG_SRC_HEIGHT: src_height_reg <= pwdata[irfa_pkg::SIZE_W-1:0];
                irfa_pkg::REG_TRUE_COLOR: true_color_reg <= pwdata[0];
                irfa_pkg::REG_ROTATE_DIR: rotate_dir_reg <= pwdata[irfa_pkg::ROT_W-1:0];
                irfa_pkg::REG_FLIP_X:     flip_x_reg     <= pwdata[0];
                irfa_pkg::REG_FLIP_Y:     flip_y_reg     <= pwdata[0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            irfa_pkg::REG_SRC_WIDTH:  prdata = irfa_pkg::DATA_W'(src_width_reg);
            irfa_pkg::REG_SRC_HEIGHT: prdata = irfa_pkg::DATA_W'(src_height_reg);
            irfa_pkg::REG_TRUE_COLOR: prdata = irfa_pkg::DATA_W'(true_color_reg);
            irfa_pkg::REG_ROTATE_DIR: prdata = irfa_pkg::DATA_W'($unsigned(rotate_dir_reg));
            irfa_pkg::REG_FLIP_X:     prdata = irfa_pkg::DATA_W'(flip_x_reg);
            irfa_pkg::REG_FLIP_Y:     prdata = irfa_pkg::DATA_W'(flip_y_reg);
            default:                  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // geometry from the registers
    // ------------------------------------------------------------------
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [irfa_pkg::SIZE_W-1:0] v);
        logic [31:0]      wide;
        logic [DIM_W-1:0] res;
        wide = 32'(v);
        if (wide == 32'd0)
            res = DIM_W'(1);
        else if (wide > 32'(MAX_DIM))
            res = DIM_W'(MAX_DIM);
        else
            res = DIM_W'(wide);
        return res;
    endfunction

    logic [DIM_W-1:0]           w_dim;
    logic [DIM_W-1:0]           h_dim;
    logic [DIM_W-1:0]           dw;
    logic [DIM_W-1:0]           dh;
    logic [DIM_W-1:0]           xd;
    logic [DIM_W-1:0]           yd;
    logic                       rot_cw;
    logic                       rot_ccw;
    logic                       turned;
    logic                       fx;
    logic                       fy;
    logic [STR_W-1:0]           dw_bytes;
    logic [STR_W-1:0]           stride;
    logic [XB_W-1:0]            xd_bytes;
    logic [PRD_W-1:0]           row_ofs;
    logic [irfa_pkg::OFS_W-1:0] start_ofs;
    logic [irfa_pkg::OFS_W-1:0] bpp_ofs;
    logic [irfa_pkg::OFS_W-1:0] stride_ofs;
    logic [irfa_pkg::OFS_W-1:0] x_step;
    logic [irfa_pkg::OFS_W-1:0] y_step;
    logic [irfa_pkg::OFS_W-1:0] xinc;
    logic [irfa_pkg::OFS_W-1:0] yinc;

    always_comb
    begin
        w_dim   = clamp_dim(src_width_reg);
        h_dim   = clamp_dim(src_height_reg);
        rot_cw  = ($unsigned(rotate_dir_reg) == irfa_pkg::ROT_CW);
        rot_ccw = rotate_dir_reg[irfa_pkg::ROT_W-1] || rot_cw;
        turned  = (rotate_dir_reg != '0);
        // clockwise is counter-clockwise with both mirrors inverted
        fx      = flip_x_reg ^ rot_cw ^ rot_ccw;
        fy      = flip_y_reg ^ rot_cw;
        dw      = turned ? h_dim : w_dim;
        dh      = turned ? w_dim : h_dim;

        dw_bytes = true_color_reg ? ((STR_W'(dw) << 1) + STR_W'(dw)) : STR_W'(dw);
        stride   = (dw_bytes + STR_W'(3)) & ~STR_W'(3);

        xd = fx ? (dw - DIM_W'(1)) : '0;
        yd = fy ? (dh - DIM_W'(1)) : '0;
        xd_bytes = true_color_reg ? ((XB_W'(xd) << 1) + XB_W'(xd)) : XB_W'(xd);

        row_ofs   = PRD_W'(yd) * PRD_W'(stride);
        start_ofs = irfa_pkg::OFS_W'(row_ofs) + irfa_pkg::OFS_W'(xd_bytes);

        bpp_ofs    = true_color_reg ? irfa_pkg::OFS_W'(3) : irfa_pkg::OFS_W'(1);
        stride_ofs = irfa_pkg::OFS_W'(stride);
        x_step     = fx ? (~bpp_ofs + irfa_pkg::OFS_W'(1)) : bpp_ofs;
        y_step     = fy ? (~stride_ofs + irfa_pkg::OFS_W'(1)) : stride_ofs;
        xinc       = rot_ccw ? y_step : x_step;
        yinc       = rot_ccw ? x_step : y_step;
    end

    // ------------------------------------------------------------------
    // raster walk
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]           col_cnt_reg;
    logic [CNT_W-1:0]           col_cnt_next;
    logic [CNT_W-1:0]           row_cnt_reg;
    logic [CNT_W-1:0]           row_cnt_next;
    logic [irfa_pkg::OFS_W-1:0] row_start_reg;
    logic [irfa_pkg::OFS_W-1:0] row_start_next;
    logic [irfa_pkg::OFS_W-1:0] cur_offset_reg;
    logic [irfa_pkg::OFS_W-1:0] cur_offset_next;
    logic [irfa_pkg::OFS_W-1:0] row_base;
    logic [irfa_pkg::OFS_W-1:0] cur_ofs;
    logic                       col_end;
    logic                       row_end;
    logic                       cur_last;
    logic                       in_accept;
    irfa_pkg::result_t          new_res;

    always_comb
    begin
        // start offset is taken from the registers at the first pixel
        row_base = ((col_cnt_reg == '0) && (row_cnt_reg == '0)) ? start_ofs : row_start_reg;
        cur_ofs  = (col_cnt_reg == '0) ? row_base : cur_offset_reg;
        col_end  = (DIM_W'(col_cnt_reg) + DIM_W'(1)) >= w_dim;
        row_end  = (DIM_W'(row_cnt_reg) + DIM_W'(1)) >= h_dim;
        cur_last = col_end && row_end;

        cur_offset_next = cur_ofs + xinc;
        if (col_end)
        begin
            col_cnt_next   = '0;
            row_cnt_next   = row_end ? '0 : (row_cnt_reg + CNT_W'(1));
            row_start_next = row_base + yinc;
        end
        else
        begin
            col_cnt_next   = col_cnt_reg + CNT_W'(1);
            row_cnt_next   = row_cnt_reg;
            row_start_next = row_base;
        end

        new_res.dest_offset = cur_ofs;
        new_res.pixel       = pixel_value;
        new_res.last        = cur_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg    <= '0;
            row_cnt_reg    <= '0;
            row_start_reg  <= '0;
            cur_offset_reg <= '0;
        end
        else if (in_accept)
        begin
            col_cnt_reg    <= col_cnt_next;
            row_cnt_reg    <= row_cnt_next;
            row_start_reg  <= row_start_next;
            cur_offset_reg <= cur_offset_next;
        end
    end

    // ------------------------------------------------------------------
    // output register with skid entry
    // ------------------------------------------------------------------
    logic              out_valid_reg;
    logic              skid_valid_reg;
    irfa_pkg::result_t out_res_reg;
    irfa_pkg::result_t skid_res_reg;
    logic              out_free;

    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || in_accept;
            skid_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_res_reg <= skid_res_reg;
            else if (in_accept)
                out_res_reg <= new_res;
        end
        else if (in_accept)
        begin
            skid_res_reg <= new_res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign dest_offset = out_res_reg.dest_offset;
    assign pixel_out   = out_res_reg.pixel;
    assign last_pixel  = out_res_reg.last;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `IRFA_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid entry without result")
    `IRFA_ASSERT_NEXT(a_last_restarts, in_accept && cur_last, (col_cnt_reg == '0) && (row_cnt_reg == '0), "walk did not restart after last pixel")
    `IRFA_ASSERT_SAME(a_skid_fill, $rose(skid_valid_reg), $past(out_valid_reg && out_stall), "skid filled while output free")

endmodule

@@ tb/sv/image_placement_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// image placement checker
// follows register writes and pixel requests, works out where each pixel
// lands after the turn and mirrors, and compares every result field by field
// ----------------------------------------------------------------------------
module image_placement_checker #(
    parameter int MAX_DIM = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [irfa_pkg::PIX_W-1:0]      pixel_value,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [irfa_pkg::OFS_W-1:0]      dest_offset,
    input  logic [irfa_pkg::PIX_W-1:0]      pixel_out,
    input  logic                            last_pixel,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [irfa_pkg::ADDR_W-1:0]     paddr,
    input  logic [irfa_pkg::DATA_W-1:0]     pwdata,
    output int                              failures,
    output int                              outstanding
);

    typedef logic [irfa_pkg::OFS_W-1:0] ofs_t;

    // register copies
    logic [irfa_pkg::SIZE_W-1:0] width_reg;
    logic [irfa_pkg::SIZE_W-1:0] height_reg;
    logic                        color_reg;
    logic [irfa_pkg::ROT_W-1:0]  rotate_reg;
    logic                        mirror_x_reg;
    logic                        mirror_y_reg;

    // walk state
    ofs_t        row_base;
    ofs_t        walk_offset;
    int unsigned col_count;
    int unsigned row_count;

    irfa_pkg::result_t awaited_placements[$];
    int                mismatches;
    int                results_seen;

    function automatic int unsigned fit_dim(input logic [irfa_pkg::SIZE_W-1:0] v);
        if (v == '0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return 32'(v);
    endfunction

    function automatic irfa_pkg::result_t place_pixel(input logic [irfa_pkg::PIX_W-1:0] pix);
        int unsigned       w;
        int unsigned       h;
        int unsigned       bpp;
        int unsigned       dw;
        int unsigned       dh;
        int unsigned       stride;
        int unsigned       xd;
        int unsigned       yd;
        logic              cw;
        logic              ccw;
        logic              turned;
        logic              fx;
        logic              fy;
        ofs_t              xinc;
        ofs_t              yinc;
        ofs_t              swap;
        irfa_pkg::result_t r;
        w      = fit_dim(width_reg);
        h      = fit_dim(height_reg);
        bpp    = color_reg ? 3 : 1;
        cw     = (rotate_reg == irfa_pkg::ROT_CW);
        ccw    = rotate_reg[irfa_pkg::ROT_W-1] || cw;
        turned = (rotate_reg != '0);
        // clockwise flips both mirrors, any turn then flips x again
        fx     = mirror_x_reg ^ cw ^ ccw;
        fy     = mirror_y_reg ^ cw;
        dw     = turned ? h : w;
        dh     = turned ? w : h;
        stride = (dw * bpp + 3) & ~32'd3;
        xd     = fx ? dw - 1 : 0;
        yd     = fy ? dh - 1 : 0;
        xinc   = fx ? ofs_t'(0 - bpp) : ofs_t'(bpp);
        yinc   = fy ? ofs_t'(0 - stride) : ofs_t'(stride);
        if (ccw)
        begin
            swap = xinc;
            xinc = yinc;
            yinc = swap;
        end
        if (col_count == 0)
        begin
            if (row_count == 0)
                row_base = ofs_t'(yd * stride + xd * bpp);
            walk_offset = row_base;
        end
        r.dest_offset = walk_offset;
        r.pixel       = pix;
        r.last        = (col_count + 1 >= w) && (row_count + 1 >= h);
        col_count++;
        walk_offset = walk_offset + xinc;
        if (col_count >= w)
        begin
            col_count = 0;
            row_base  = row_base + yinc;
            row_count++;
            if (row_count >= h)
                row_count = 0;
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch on %s at result %0d: got 0x%0h, want 0x%0h",
                 what, results_seen, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        irfa_pkg::result_t want;
        if (!rst_n)
        begin
            width_reg    = irfa_pkg::SIZE_W'(1);
            height_reg   = irfa_pkg::SIZE_W'(1);
            color_reg    = 1'b0;
            rotate_reg   = '0;
            mirror_x_reg = 1'b0;
            mirror_y_reg = 1'b0;
            row_base     = '0;
            walk_offset  = '0;
            col_count    = 0;
            row_count    = 0;
            mismatches   = 0;
            results_seen = 0;
            awaited_placements.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[irfa_pkg::ADDR_W-1:2])
                    irfa_pkg::REG_SRC_WIDTH:  width_reg    = pwdata[irfa_pkg::SIZE_W-1:0];
                    irfa_pkg::REG_SRC_HEIGHT: height_reg   = pwdata[irfa_pkg::SIZE_W-1:0];
                    irfa_pkg::REG_TRUE_COLOR: color_reg    = pwdata[0];
                    irfa_pkg::REG_ROTATE_DIR: rotate_reg   = pwdata[irfa_pkg::ROT_W-1:0];
                    irfa_pkg::REG_FLIP_X:     mirror_x_reg = pwdata[0];
                    irfa_pkg::REG_FLIP_Y:     mirror_y_reg = pwdata[0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                awaited_placements.push_back(place_pixel(pixel_value));
            if (out_valid && !out_stall)
            begin
                if (awaited_placements.size() == 0)
                    flag_mismatch("result with no request pending", 32'(dest_offset), '0);
                else
                begin
                    want = awaited_placements.pop_front();
                    if (dest_offset !== want.dest_offset)
                        flag_mismatch("dest_offset", 32'(dest_offset),
                                      32'(want.dest_offset));
                    if (pixel_out !== want.pixel)
                        flag_mismatch("pixel_out", 32'(pixel_out), 32'(want.pixel));
                    if (last_pixel !== want.last)
                        flag_mismatch("last_pixel", 32'(last_pixel), 32'(want.last));
                end
                results_seen++;
            end
        end
        failures    <= mismatches;
        outstanding <= awaited_placements.size();
    end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotate/flip address unit testbench
// programs image geometry over the register port, streams pixels with random
// gaps against a stalling receiver, and leaves checking to the placement checker
// ----------------------------------------------------------------------------
module testbench;

    localparam int                         RANDOM_ITEMS = 1450;
    localparam int                         IDLE_LIMIT   = 2000;
    localparam int                         HOLD_CYCLES  = 80;
    localparam logic [irfa_pkg::ROT_W-1:0] ROT_NONE     = 2'b00;
    localparam logic [irfa_pkg::ROT_W-1:0] ROT_CCW      = 2'b11;
    localparam logic [irfa_pkg::ROT_W-1:0] ROT_CCW2     = 2'b10;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic [irfa_pkg::PIX_W-1:0]     pixel_value;
    logic                           out_valid;
    logic                           out_stall;
    logic [irfa_pkg::OFS_W-1:0]     dest_offset;
    logic [irfa_pkg::PIX_W-1:0]     pixel_out;
    logic                           last_pixel;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [irfa_pkg::ADDR_W-1:0]    paddr;
    logic [irfa_pkg::DATA_W-1:0]    pwdata;
    logic [irfa_pkg::DATA_W-1:0]    prdata;
    logic                           pready;

    int failures;
    int outstanding;
    int items_sent;
    int burst_left;
    int idle_cycles;
    bit sender_calm;
    bit long_hold_req;

    image_rotate_flip_address_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_value (pixel_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .dest_offset (dest_offset),
        .pixel_out   (pixel_out),
        .last_pixel  (last_pixel),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    image_placement_checker placement_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_value (pixel_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .dest_offset (dest_offset),
        .pixel_out   (pixel_out),
        .last_pixel  (last_pixel),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .failures    (failures),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // psel stays high across back-to-back writes; configure drops it
    task automatic write_reg(input logic [irfa_pkg::IDX_W-1:0] idx,
                             input logic [irfa_pkg::DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= irfa_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
    endtask

    task automatic configure(input logic [irfa_pkg::SIZE_W-1:0] w,
                             input logic [irfa_pkg::SIZE_W-1:0] h,
                             input bit tc, input logic [irfa_pkg::ROT_W-1:0] rot,
                             input bit fx, input bit fy);
        write_reg(irfa_pkg::REG_SRC_WIDTH, irfa_pkg::DATA_W'(w));
        write_reg(irfa_pkg::REG_SRC_HEIGHT, irfa_pkg::DATA_W'(h));
        write_reg(irfa_pkg::REG_TRUE_COLOR, irfa_pkg::DATA_W'(tc));
        write_reg(irfa_pkg::REG_ROTATE_DIR, irfa_pkg::DATA_W'(rot));
        write_reg(irfa_pkg::REG_FLIP_X, irfa_pkg::DATA_W'(fx));
        write_reg(irfa_pkg::REG_FLIP_Y, irfa_pkg::DATA_W'(fy));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // valid stays high from one call to the next; drain lowers it
    task automatic push_pixels(input int count, input bit extremes);
        int gap;
        for (int k = 0; k < count; k++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap = sender_calm ? 0 : $urandom_range(0, 5);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
            in_valid    <= 1'b1;
            pixel_value <= extremes ? ((k % 2) ? '1 : '0) : irfa_pkg::PIX_W'($urandom);
            @(posedge clk);
            while (in_stall) @(posedge clk);
            items_sent++;
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        // margin behind the registered outstanding count
        repeat (2) @(posedge clk);
    endtask

    function automatic logic [irfa_pkg::SIZE_W-1:0] edge_dim();
        case ($urandom_range(0, 5))
            0:       return irfa_pkg::SIZE_W'(0);
            1:       return irfa_pkg::SIZE_W'(1);
            2:       return irfa_pkg::SIZE_W'(4095);
            3:       return irfa_pkg::SIZE_W'(4096);
            4:       return irfa_pkg::SIZE_W'(4097);
            default: return '1;
        endcase
    endfunction

    // receiver: pattern modes plus an occasional long hold-off
    initial
    begin
        int hold_left = 0;
        int mode = 0;
        int mode_left = 0;
        int phase = 0;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            phase++;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ((phase % 5) < 2);
                    default: out_stall <= ($urandom_range(0, 1) == 0);
                endcase
            end
        end
    end

    // watchdog on cycles with no traffic at all
    always @(posedge clk)
    begin
        if (!rst_n || psel || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        logic [irfa_pkg::SIZE_W-1:0] w;
        logic [irfa_pkg::SIZE_W-1:0] h;
        int sel;
        int count;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        pixel_value <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        items_sent  = 0;
        burst_left  = 0;
        sender_calm = 1'b0;
        long_hold_req = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-pixel images under the reset settings
        push_pixels(2, 1'b1);
        drain();
        // mirror switched on mid-row walks the offset below zero
        configure(4, 1, 1'b0, ROT_NONE, 1'b0, 1'b0);
        push_pixels(1, 1'b1);
        drain();
        configure(4, 1, 1'b0, ROT_NONE, 1'b1, 1'b0);
        push_pixels(3, 1'b1);
        drain();
        // padded stride with both mirrors
        configure(3, 2, 1'b1, ROT_NONE, 1'b1, 1'b1);
        push_pixels(6, 1'b1);
        drain();
        // counter-clockwise with mirror y
        configure(5, 3, 1'b0, ROT_CCW, 1'b0, 1'b1);
        push_pixels(6, 1'b1);
        drain();
        // zero width, oversize height, rotate code -2
        configure(0, '1, 1'b0, ROT_CCW2, 1'b0, 1'b0);
        push_pixels(3, 1'b1);
        drain();
        // largest image turned clockwise: start offset near the top
        configure(4096, 4096, 1'b1, irfa_pkg::ROT_CW, 1'b0, 1'b0);
        push_pixels(3, 1'b1);
        drain();
        // width shrunk under a running row
        configure(2, 4096, 1'b1, irfa_pkg::ROT_CW, 1'b1, 1'b1);
        push_pixels(2, 1'b1);
        drain();

        long_hold_req = 1'b1;
        while (items_sent < RANDOM_ITEMS + 26)
        begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
            begin
                w = edge_dim();
                h = edge_dim();
                count = $urandom_range(1, 40);
            end
            else
            begin
                w = irfa_pkg::SIZE_W'($urandom_range(1, 12));
                h = irfa_pkg::SIZE_W'($urandom_range(1, 8));
                count = (sel < 8) ? w * h : $urandom_range(1, 30);
            end
            sender_calm = ($urandom_range(0, 3) == 0);
            configure(w, h, 1'($urandom), irfa_pkg::ROT_W'($urandom),
                      1'($urandom), 1'($urandom));
            if ($urandom_range(0, 15) == 0)
                long_hold_req = 1'b1;
            push_pixels(count, 1'b0);
            if ($urandom_range(0, 2) == 0)
                push_pixels(count, 1'b0);
            drain();
        end

        repeat (4) @(posedge clk);
        if (failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ image_rotate_flip_address_unit.f @@
+incdir+rtl/core
rtl/core/irfa_pkg.sv
rtl/core/image_rotate_flip_address_unit.sv
tb/sv/image_placement_checker.sv
tb/sv/testbench.sv
